### rtl/uer_pkg.sv
`default_nettype none
package uer_pkg;

  // Width of the echo and trigger tick counter.
  localparam int COUNT_WIDTH = 16;

  // Register field widths.
  localparam int TICKS_W = 16;
  localparam int DIVISOR_W = 20;
  localparam int DIST_W = 17;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 3;

  // Comparison width that holds both the counter and a tick register.
  localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

  // Count times 10000 needs 14 more bits than the count.
  localparam int SCALE_W = 14;
  localparam int PROD_W = COUNT_WIDTH + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(10000);

  // Step counter in the controller covers the divider and the digit passes.
  localparam int NUM_DIGITS = 5;
  localparam int STEP_W = $clog2(PROD_W);

  // Largest distance shown, in hundredths of a centimeter.
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(99999);

  // Divide by ten as multiply by 52429 and shift by 19, exact below 2^17.
  localparam int DIV10_MUL_W = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(52429);
  localparam int DIV10_SHIFT = 19;
  localparam int DIV10_PROD_W = DIST_W + DIV10_MUL_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_100CM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT = 3'd4;

  // Configuration reset values.
  localparam logic [TICKS_W-1:0] TRIGGER_TICKS_RST = TICKS_W'(80);
  localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = TICKS_W'(60000);
  localparam logic [DIVISOR_W-1:0] TICKS_PER_100CM_RST = DIVISOR_W'(46647);
  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = DIST_W'(200);
  localparam logic [DIST_W-1:0] FAR_LIMIT_RST = DIST_W'(4000);

  // Measurement phase of the ranger.
  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_MEASURE = 2'd2
  } uer_phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_DIG,
    ST_WRITE
  } uer_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic div_step;
    logic finish;
    logic dig_step;
    logic out_load;
  } uer_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fall;
    logic out_free;
  } uer_sts_t;

endpackage
`default_nettype wire

### rtl/ultrasonic_echo_ranger.sv
// A tick that ends no measurement is taken in the idle state, and its word is loaded
// from the write state, which waits out output stalls; the next tick waits for that load.
// A tick on the falling echo edge runs one multiply, a 30-step bit-serial divider
// (count width plus 14) and five divide-by-ten digit passes before its word is written.
// Reset is synchronous, active low, and skips the working and output word registers.
`default_nettype none
module ultrasonic_echo_ranger (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_echo_level,
  input  wire logic                            cfg_wr_en,
  input  wire logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_trigger_out,
  output logic                                 out_done_res,
  output logic                                 out_timed_out,
  output logic                                 out_object_near,
  output logic [uer_pkg::DIST_W-1:0]           out_distance_hundredths,
  output logic [1:0]                           out_int_digit_count,
  output logic [3:0]                           out_digit_hundreds,
  output logic [3:0]                           out_digit_tens,
  output logic [3:0]                           out_digit_units,
  output logic [3:0]                           out_digit_tenths,
  output logic [3:0]                           out_digit_hundredths
);

  uer_pkg::uer_cmd_t cmd;
  uer_pkg::uer_sts_t sts;

  // Sequencing of ticks, division and digit passes.
  uer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Phase logic, divider, digit extraction and output word.
  uer_dpath u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_echo_level           (in_echo_level),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_trigger_out         (out_trigger_out),
    .out_done_res            (out_done_res),
    .out_timed_out           (out_timed_out),
    .out_object_near         (out_object_near),
    .out_distance_hundredths (out_distance_hundredths),
    .out_int_digit_count     (out_int_digit_count),
    .out_digit_hundreds      (out_digit_hundreds),
    .out_digit_tens          (out_digit_tens),
    .out_digit_units         (out_digit_units),
    .out_digit_tenths        (out_digit_tenths),
    .out_digit_hundredths    (out_digit_hundredths)
  );

endmodule
`default_nettype wire

### rtl/uer_ctrl.sv
`default_nettype none
module uer_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire uer_pkg::uer_sts_t sts,
  output uer_pkg::uer_cmd_t      cmd
);

  uer_pkg::uer_state_t state_r, state_nxt;
  logic [uer_pkg::STEP_W-1:0] step_cnt_r, step_cnt_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= uer_pkg::ST_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      uer_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.step     = 1'b1;
          step_cnt_nxt = '0;
          state_nxt    = sts.fall ? uer_pkg::ST_DIV : uer_pkg::ST_WRITE;
        end
      end
      uer_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == uer_pkg::STEP_W'(uer_pkg::PROD_W - 1)) begin
          state_nxt = uer_pkg::ST_FIN;
        end
      end
      uer_pkg::ST_FIN: begin
        cmd.finish   = 1'b1;
        step_cnt_nxt = '0;
        state_nxt    = uer_pkg::ST_DIG;
      end
      uer_pkg::ST_DIG: begin
        cmd.dig_step = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == uer_pkg::STEP_W'(uer_pkg::NUM_DIGITS - 1)) begin
          state_nxt = uer_pkg::ST_WRITE;
        end
      end
      uer_pkg::ST_WRITE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = uer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = uer_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/uer_dpath.sv
`default_nettype none
module uer_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire uer_pkg::uer_cmd_t                 cmd,
  output uer_pkg::uer_sts_t                      sts,
  input  wire logic                              in_echo_level,
  input  wire logic                              cfg_wr_en,
  input  wire logic [uer_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic                                   out_trigger_out,
  output logic                                   out_done_res,
  output logic                                   out_timed_out,
  output logic                                   out_object_near,
  output logic [uer_pkg::DIST_W-1:0]             out_distance_hundredths,
  output logic [1:0]                             out_int_digit_count,
  output logic [3:0]                             out_digit_hundreds,
  output logic [3:0]                             out_digit_tens,
  output logic [3:0]                             out_digit_units,
  output logic [3:0]                             out_digit_tenths,
  output logic [3:0]                             out_digit_hundredths
);

  localparam int CW = uer_pkg::COUNT_WIDTH;
  localparam int PW = uer_pkg::PROD_W;
  localparam int DW = uer_pkg::DIVISOR_W;
  localparam int SW = uer_pkg::DIST_W;

  // Configuration registers.
  logic [uer_pkg::TICKS_W-1:0] trigger_ticks_r;
  logic [uer_pkg::TICKS_W-1:0] timeout_ticks_r;
  logic [DW-1:0]               divisor_r;
  logic [SW-1:0]               near_limit_r;
  logic [SW-1:0]               far_limit_r;

  // Measurement state.
  uer_pkg::uer_phase_t phase_r, phase_nxt;
  logic [CW-1:0]       tick_count_r, tick_count_nxt;
  logic                timed_out_r, timed_out_nxt;
  logic                indicator_r, indicator_nxt;
  logic [SW-1:0]       distance_r;
  logic                trig_r, trig_nxt;
  logic                done_r, done_nxt;
  logic [3:0]          digit_r [uer_pkg::NUM_DIGITS];

  // Divider and digit working registers.
  logic [PW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [SW-1:0] dig_work_r;

  logic out_valid_r;

  // Output word registers.
  logic          out_trigger_out_r;
  logic          out_done_res_r;
  logic          out_timed_out_r;
  logic          out_object_near_r;
  logic [SW-1:0] out_distance_hundredths_r;
  logic [1:0]    out_int_digit_count_r;
  logic [3:0]    out_digit_hundreds_r;
  logic [3:0]    out_digit_tens_r;
  logic [3:0]    out_digit_units_r;
  logic [3:0]    out_digit_tenths_r;
  logic [3:0]    out_digit_hundredths_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= uer_pkg::TRIGGER_TICKS_RST;
      timeout_ticks_r <= uer_pkg::TIMEOUT_TICKS_RST;
      divisor_r       <= uer_pkg::TICKS_PER_100CM_RST;
      near_limit_r    <= uer_pkg::NEAR_LIMIT_RST;
      far_limit_r     <= uer_pkg::FAR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_TICKS:   trigger_ticks_r <= cfg_wdata[uer_pkg::TICKS_W-1:0];
        uer_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks_r <= cfg_wdata[uer_pkg::TICKS_W-1:0];
        uer_pkg::CFG_TICKS_PER_100CM: divisor_r       <= cfg_wdata[DW-1:0];
        uer_pkg::CFG_NEAR_LIMIT:      near_limit_r    <= cfg_wdata[SW-1:0];
        uer_pkg::CFG_FAR_LIMIT:       far_limit_r     <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Saturating tick increment and end-of-count checks.
  logic          cnt_at_max;
  logic [CW-1:0] cnt_inc;
  logic          inc_at_max;
  logic          trig_end;
  logic          timeout_hit;

  assign cnt_at_max  = (tick_count_r == {CW{1'b1}});
  assign cnt_inc     = cnt_at_max ? tick_count_r : tick_count_r + 1'b1;
  assign inc_at_max  = (cnt_inc == {CW{1'b1}});
  assign trig_end    = (uer_pkg::CMP_W'(cnt_inc) >= uer_pkg::CMP_W'(trigger_ticks_r))
                       || inc_at_max;
  assign timeout_hit = (uer_pkg::CMP_W'(cnt_inc) >= uer_pkg::CMP_W'(timeout_ticks_r))
                       || inc_at_max;

  assign sts.fall     = (phase_r == uer_pkg::PH_MEASURE) && !in_echo_level;
  assign sts.out_free = !out_valid_r || !out_stall;

  // One tick of the phase sequence.
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    timed_out_nxt  = timed_out_r;
    indicator_nxt  = indicator_r;
    trig_nxt       = 1'b0;
    done_nxt       = 1'b0;
    unique case (phase_r)
      uer_pkg::PH_WAIT: begin
        if (in_echo_level) begin
          phase_nxt      = uer_pkg::PH_MEASURE;
          tick_count_nxt = '0;
        end
      end
      uer_pkg::PH_MEASURE: begin
        if (in_echo_level) begin
          tick_count_nxt = cnt_inc;
          if (timeout_hit) begin
            timed_out_nxt  = 1'b1;
            indicator_nxt  = 1'b0;
            done_nxt       = 1'b1;
            phase_nxt      = uer_pkg::PH_TRIGGER;
            tick_count_nxt = '0;
          end
        end else begin
          // Falling edge: distance follows from the divider.
          timed_out_nxt  = 1'b0;
          done_nxt       = 1'b1;
          phase_nxt      = uer_pkg::PH_TRIGGER;
          tick_count_nxt = '0;
        end
      end
      default: begin
        trig_nxt       = 1'b1;
        phase_nxt      = uer_pkg::PH_TRIGGER;
        tick_count_nxt = cnt_inc;
        if (trig_end) begin
          phase_nxt      = uer_pkg::PH_WAIT;
          tick_count_nxt = '0;
        end
      end
    endcase
  end

  // Restoring divider step.
  logic [DW:0] div_shift;
  logic        div_fits;

  assign div_shift = {rem_r, quo_r[PW-1]};
  assign div_fits  = (div_shift >= (DW+1)'(divisor_r));

  // Saturated distance from the quotient.
  logic [SW-1:0] dist_sat;
  assign dist_sat = ((divisor_r == '0) || (quo_r > PW'(uer_pkg::DIST_MAX)))
                    ? uer_pkg::DIST_MAX : quo_r[SW-1:0];

  // Divide by ten for one decimal digit.
  logic [uer_pkg::DIV10_PROD_W-1:0] d10_prod;
  logic [SW-1:0]                    d10_quo;
  logic [SW-1:0]                    d10_rem;

  assign d10_prod = uer_pkg::DIV10_PROD_W'(dig_work_r)
                    * uer_pkg::DIV10_PROD_W'(uer_pkg::DIV10_MUL);
  assign d10_quo  = SW'(d10_prod >> uer_pkg::DIV10_SHIFT);
  assign d10_rem  = dig_work_r - ((d10_quo << 3) + (d10_quo << 1));

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= uer_pkg::PH_TRIGGER;
      tick_count_r <= '0;
      timed_out_r  <= 1'b0;
      indicator_r  <= 1'b0;
      distance_r   <= '0;
      trig_r       <= 1'b0;
      done_r       <= 1'b0;
      for (int i = 0; i < uer_pkg::NUM_DIGITS; i++) begin
        digit_r[i] <= '0;
      end
    end else begin
      if (cmd.step) begin
        phase_r      <= phase_nxt;
        tick_count_r <= tick_count_nxt;
        timed_out_r  <= timed_out_nxt;
        indicator_r  <= indicator_nxt;
        trig_r       <= trig_nxt;
        done_r       <= done_nxt;
      end
      if (cmd.finish) begin
        distance_r  <= dist_sat;
        indicator_r <= (dist_sat >= near_limit_r) && (dist_sat <= far_limit_r);
      end
      // Digits shift in from the top, least significant extracted first.
      if (cmd.dig_step) begin
        for (int i = 0; i < uer_pkg::NUM_DIGITS - 1; i++) begin
          digit_r[i] <= digit_r[i+1];
        end
        digit_r[uer_pkg::NUM_DIGITS-1] <= d10_rem[3:0];
      end
    end
  end

  // Divider and digit working registers.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      quo_r <= PW'(tick_count_r) * PW'(uer_pkg::SCALE);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[PW-2:0], div_fits};
      rem_r <= div_fits ? DW'(div_shift - (DW+1)'(divisor_r)) : div_shift[DW-1:0];
    end
    if (cmd.finish) begin
      dig_work_r <= dist_sat;
    end else if (cmd.dig_step) begin
      dig_work_r <= d10_quo;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Integer digit count from the distance.
  logic [1:0] int_digits;
  always_comb begin
    priority if (distance_r >= SW'(10000)) begin
      int_digits = 2'd3;
    end else if (distance_r >= SW'(1000)) begin
      int_digits = 2'd2;
    end else if (distance_r >= SW'(100)) begin
      int_digits = 2'd1;
    end else begin
      int_digits = 2'd0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_trigger_out_r         <= trig_r;
      out_done_res_r            <= done_r;
      out_timed_out_r           <= timed_out_r;
      out_object_near_r         <= indicator_r;
      out_distance_hundredths_r <= distance_r;
      out_int_digit_count_r     <= int_digits;
      out_digit_hundreds_r      <= digit_r[4];
      out_digit_tens_r          <= digit_r[3];
      out_digit_units_r         <= digit_r[2];
      out_digit_tenths_r        <= digit_r[1];
      out_digit_hundredths_r    <= digit_r[0];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_trigger_out         = out_trigger_out_r;
  assign out_done_res            = out_done_res_r;
  assign out_timed_out           = out_timed_out_r;
  assign out_object_near         = out_object_near_r;
  assign out_distance_hundredths = out_distance_hundredths_r;
  assign out_int_digit_count     = out_int_digit_count_r;
  assign out_digit_hundreds      = out_digit_hundreds_r;
  assign out_digit_tens          = out_digit_tens_r;
  assign out_digit_units         = out_digit_units_r;
  assign out_digit_tenths        = out_digit_tenths_r;
  assign out_digit_hundredths    = out_digit_hundredths_r;

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  localparam int TICK_TARGET = 1100;
  localparam int PRINT_LIMIT = 50;
  localparam int DIST_SAT = 99999;

  // One result word, field by field.
  typedef struct packed {
    logic             trig;
    logic             done;
    logic             tmo;
    logic             near;
    logic [DIST_W-1:0] dist_hd;
    logic [1:0]       ndig;
    logic [3:0]       d100;
    logic [3:0]       d10;
    logic [3:0]       d1;
    logic [3:0]       d01;
    logic [3:0]       d001;
  } range_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_echo_level = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_TRIGGER_TICKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_trigger_out;
  logic out_done_res;
  logic out_timed_out;
  logic out_object_near;
  logic [DIST_W-1:0] out_distance_hundredths;
  logic [1:0] out_int_digit_count;
  logic [3:0] out_digit_hundreds;
  logic [3:0] out_digit_tens;
  logic [3:0] out_digit_units;
  logic [3:0] out_digit_tenths;
  logic [3:0] out_digit_hundredths;

  ultrasonic_echo_ranger dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_echo_level(in_echo_level),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger_out(out_trigger_out),
    .out_done_res(out_done_res),
    .out_timed_out(out_timed_out),
    .out_object_near(out_object_near),
    .out_distance_hundredths(out_distance_hundredths),
    .out_int_digit_count(out_int_digit_count),
    .out_digit_hundreds(out_digit_hundreds),
    .out_digit_tens(out_digit_tens),
    .out_digit_units(out_digit_units),
    .out_digit_tenths(out_digit_tenths),
    .out_digit_hundredths(out_digit_hundredths)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracked copy of the ranger registers and measurement state.
  logic [TICKS_W-1:0] trk_trig_len;
  logic [TICKS_W-1:0] trk_timeout;
  logic [DIVISOR_W-1:0] trk_divisor;
  logic [DIST_W-1:0] trk_near_lim;
  logic [DIST_W-1:0] trk_far_lim;
  uer_phase_t trk_phase;
  logic [COUNT_WIDTH-1:0] trk_count;
  logic [DIST_W-1:0] trk_dist;
  logic trk_timed_out;
  logic trk_lit;

  range_word_t expected_words[$];
  int err_count = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  task automatic reset_tracker();
    trk_trig_len = TRIGGER_TICKS_RST;
    trk_timeout = TIMEOUT_TICKS_RST;
    trk_divisor = TICKS_PER_100CM_RST;
    trk_near_lim = NEAR_LIMIT_RST;
    trk_far_lim = FAR_LIMIT_RST;
    trk_phase = PH_TRIGGER;
    trk_count = '0;
    trk_dist = '0;
    trk_timed_out = 1'b0;
    trk_lit = 1'b0;
  endtask

  // Advance the tracked ranger by one tick and return the word it shows.
  function automatic range_word_t track_tick(logic echo);
    range_word_t w;
    longint unsigned quot;
    int unsigned cm;
    w = '0;
    case (trk_phase)
      PH_WAIT: begin
        if (echo) begin
          trk_phase = PH_MEASURE;
          trk_count = '0;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (trk_count != '1) trk_count = trk_count + 1'b1;
          if (trk_count >= trk_timeout || trk_count == '1) begin
            trk_timed_out = 1'b1;
            trk_lit = 1'b0;
            w.done = 1'b1;
            trk_phase = PH_TRIGGER;
            trk_count = '0;
          end
        end else begin
          // Falling edge: scale the count into hundredths of a centimeter.
          if (trk_divisor == '0) begin
            quot = DIST_SAT;
          end else begin
            quot = (longint'(trk_count) * 10000) / longint'(trk_divisor);
            if (quot > DIST_SAT) quot = DIST_SAT;
          end
          trk_dist = DIST_W'(quot);
          trk_timed_out = 1'b0;
          trk_lit = (trk_dist >= trk_near_lim) && (trk_dist <= trk_far_lim);
          w.done = 1'b1;
          trk_phase = PH_TRIGGER;
          trk_count = '0;
        end
      end
      default: begin
        // Trigger phase; an unused phase code behaves the same way.
        trk_phase = PH_TRIGGER;
        w.trig = 1'b1;
        if (trk_count != '1) trk_count = trk_count + 1'b1;
        if (trk_count >= trk_trig_len || trk_count == '1) begin
          trk_phase = PH_WAIT;
          trk_count = '0;
        end
      end
    endcase

    // Display digits always follow the last distance.
    cm = trk_dist / 100;
    w.tmo = trk_timed_out;
    w.near = trk_lit;
    w.dist_hd = trk_dist;
    w.ndig = (cm >= 100) ? 2'd3 : (cm >= 10) ? 2'd2 : (cm >= 1) ? 2'd1 : 2'd0;
    w.d100 = 4'((cm / 100) % 10);
    w.d10 = 4'((cm / 10) % 10);
    w.d1 = 4'(cm % 10);
    w.d01 = 4'((trk_dist / 10) % 10);
    w.d001 = 4'(trk_dist % 10);
    return w;
  endfunction

  task automatic flag_error(string msg);
    if (err_count < PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cmp_field(string name, int unsigned got, int unsigned want);
    if (got != want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_word();
    range_word_t w;
    if (expected_words.size() == 0) begin
      flag_error("result word with no tick outstanding");
    end else begin
      w = expected_words.pop_front();
      cmp_field("trigger_out", out_trigger_out, w.trig);
      cmp_field("done_res", out_done_res, w.done);
      cmp_field("timed_out", out_timed_out, w.tmo);
      cmp_field("object_near", out_object_near, w.near);
      cmp_field("distance_hundredths", out_distance_hundredths, w.dist_hd);
      cmp_field("int_digit_count", out_int_digit_count, w.ndig);
      cmp_field("digit_hundreds", out_digit_hundreds, w.d100);
      cmp_field("digit_tens", out_digit_tens, w.d10);
      cmp_field("digit_units", out_digit_units, w.d1);
      cmp_field("digit_tenths", out_digit_tenths, w.d01);
      cmp_field("digit_hundredths", out_digit_hundredths, w.d001);
    end
  endtask

  // Result side: take a word, then hold stall for a random number of cycles.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) begin
      check_word();
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Hang detector: nothing accepted on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one tick word and record what it should produce.
  task automatic send_tick(logic echo);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo_level <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(track_tick(echo));
    ticks_sent++;
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TRIGGER_TICKS: trk_trig_len = val[TICKS_W-1:0];
      CFG_TIMEOUT_TICKS: trk_timeout = val[TICKS_W-1:0];
      CFG_TICKS_PER_100CM: trk_divisor = val[DIVISOR_W-1:0];
      CFG_NEAR_LIMIT: trk_near_lim = val[DIST_W-1:0];
      CFG_FAR_LIMIT: trk_far_lim = val[DIST_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed measurement: finish the trigger, wait, then an echo pulse.
  task automatic measure(int highs);
    while (trk_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) send_tick(1'b0);
    send_tick(1'b1);
    repeat (highs) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_default_settings();
    measure($urandom_range(10, 40));
  endtask

  // A zero trigger length acts as a single tick.
  task automatic test_trigger_length();
    set_reg(CFG_TRIGGER_TICKS, 0);
    measure(2);
    set_reg(CFG_TRIGGER_TICKS, 1);
    measure(0);
  endtask

  // Timeouts at zero, one and a few ticks, and an echo that ends just short.
  task automatic test_timeout();
    set_reg(CFG_TIMEOUT_TICKS, 0);
    measure(1);
    set_reg(CFG_TIMEOUT_TICKS, 1);
    measure(1);
    measure(0);
    set_reg(CFG_TIMEOUT_TICKS, 4);
    measure(3);
    measure(4);
  endtask

  // Saturation, zero divisor, the largest divisor and every digit count.
  task automatic test_distance_range();
    set_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
    set_reg(CFG_TICKS_PER_100CM, 0);
    measure(5);
    set_reg(CFG_TICKS_PER_100CM, 1);
    measure(10);
    set_reg(CFG_TICKS_PER_100CM, 20'hFFFFF);
    measure(30);
    set_reg(CFG_TICKS_PER_100CM, 100);
    measure(1);
    measure(10);
    set_reg(CFG_TICKS_PER_100CM, 3);
    measure(7);
    measure(1);
  endtask

  // Indicator window edges, an inverted window, limits above full scale,
  // and a timeout that turns a lit indicator off.
  task automatic test_indicator_window();
    set_reg(CFG_TICKS_PER_100CM, 100);
    set_reg(CFG_NEAR_LIMIT, 300);
    set_reg(CFG_FAR_LIMIT, 300);
    measure(3);
    measure(2);
    set_reg(CFG_NEAR_LIMIT, 17'h1FFFF);
    set_reg(CFG_FAR_LIMIT, 17'h1FFFF);
    measure(4);
    set_reg(CFG_NEAR_LIMIT, 0);
    measure(0);
    set_reg(CFG_TIMEOUT_TICKS, 2);
    measure(5);
    set_reg(CFG_NEAR_LIMIT, 500);
    set_reg(CFG_FAR_LIMIT, 400);
    measure(4);
  endtask

  // Full-scale trigger and timeout lengths, cut short by a later write.
  task automatic test_long_counts();
    set_reg(CFG_TRIGGER_TICKS, 16'hFFFF);
    set_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
    repeat (20) send_tick(1'($urandom_range(0, 1)));
    set_reg(CFG_TRIGGER_TICKS, 2);
    while (trk_phase != PH_WAIT) send_tick(1'b0);
    send_tick(1'b1);
    repeat (20) send_tick(1'b1);
    set_reg(CFG_TIMEOUT_TICKS, 7);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Random settings per phase; mostly clean echo pulses, some noise.
  task automatic test_random_phases();
    int sel;
    logic [CFG_DATA_W-1:0] near_v;
    while (ticks_sent < TICK_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      set_reg(CFG_TRIGGER_TICKS, $urandom_range(0, 6));
      sel = $urandom_range(0, 3);
      set_reg(CFG_TIMEOUT_TICKS, (sel == 0) ? 16'hFFFF :
                                 (sel == 1) ? 20'($urandom_range(0, 65535)) :
                                 20'($urandom_range(0, 40)));
      sel = $urandom_range(0, 5);
      case (sel)
        0: set_reg(CFG_TICKS_PER_100CM, 0);
        1: set_reg(CFG_TICKS_PER_100CM, $urandom_range(1, 50));
        2: set_reg(CFG_TICKS_PER_100CM, $urandom_range(50, 5000));
        3: set_reg(CFG_TICKS_PER_100CM, $urandom_range(10000, 1000000));
        default: set_reg(CFG_TICKS_PER_100CM, 20'($urandom()));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        set_reg(CFG_NEAR_LIMIT, 17'($urandom()));
        set_reg(CFG_FAR_LIMIT, 17'($urandom()));
      end else begin
        near_v = $urandom_range(0, 5000);
        set_reg(CFG_NEAR_LIMIT, near_v);
        set_reg(CFG_FAR_LIMIT, near_v + $urandom_range(0, 20000));
      end
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(5, 20)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          measure($urandom_range(0, 50));
        end
      end
    end
  endtask

  initial begin
    reset_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_default_settings();
    test_trigger_length();
    test_timeout();
    test_distance_range();
    test_indicator_window();
    test_long_counts();
    test_random_phases();
    settle();
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
